// ----- hdl/wcsa_pkg.sv -----
// ----------------------------------------------------------------------------
// wcsa_pkg
// Types, codes and saturating arithmetic for the weighted cell statistics
// accumulator.
// ----------------------------------------------------------------------------
package wcsa_pkg;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic               op;
      logic               dead;
      logic [1:0]         time_index;
      logic [3:0]         x_index;
      logic [3:0]         y_index;
      logic [3:0]         z_index;
      logic [31:0]        weight;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [6:0]         charge;
   } req_type;

   typedef struct packed {
      logic [31:0]        hit_count;
      logic [63:0]        weight_sum;
      logic signed [63:0] vel_x_sum;
      logic signed [63:0] vel_y_sum;
      logic signed [63:0] vel_z_sum;
      logic [63:0]        charge_sum;
   } rsp_type;

   // One memory word holds every sum of one cell
   typedef struct packed {
      logic [31:0] count;
      logic [63:0] weight_sum;
      logic [63:0] vel_x_sum;
      logic [63:0] vel_y_sum;
      logic [63:0] vel_z_sum;
      logic [63:0] charge_sum;
   } cell_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_WRITE
   } state_type;

   function automatic logic [63:0] sat_add_u(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   function automatic logic [63:0] sat_add_s(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      logic [63:0] r;
      s = a + b;
      r = s;
      if ((a[63] == b[63]) && (s[63] != a[63])) begin
         r = a[63] ? S64_MIN : S64_MAX;
      end
      return r;
   endfunction

endpackage

// ----- hdl/weighted_cell_stats_accumulator.sv -----
// ----------------------------------------------------------------------------
// weighted_cell_stats_accumulator
// Scatter-accumulates weighted particle samples into a grid of cells held in
// one wide memory, and reads back the sums of one cell on request.
//
// Request channel (req_valid / req_stall / req_payload): an accumulate item
// with a live particle and in-range indices occupies the block through the
// IDLE, FETCH and WRITE states (accept with memory read, multiply, saturating
// add and write-back). A read item occupies it through IDLE and FETCH, where
// it waits while a stalled result fills the response register, and its result
// sits in the response register the cycle after FETCH. Dead or out-of-range
// accumulate items are taken in IDLE alone. One item is in flight at a time,
// so read-modify-write of one cell never overlaps another.
// Response channel (rsp_valid / rsp_stall / rsp_payload): a one-entry output
// register. A stalled result holds; a following item is still accepted and
// only a second read waits for the register to drain.
// Reset: a clearing pass zeroes every cell, one per cycle, while req_stall
// stays high; there are TIME_BINS * X_BINS * Y_BINS * Z_BINS cells (16384
// with default parameters). csr_wr_en / csr_wr_data write the time step at
// any time; it resets to zero.
// ----------------------------------------------------------------------------
module weighted_cell_stats_accumulator #(
   parameter int TIME_BINS = 4,
   parameter int X_BINS    = 16,
   parameter int Y_BINS    = 16,
   parameter int Z_BINS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wcsa_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wcsa_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   localparam int CELLS  = TIME_BINS * X_BINS * Y_BINS * Z_BINS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CELL_W = $bits(wcsa_pkg::cell_type);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

   // control
   wcsa_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         time_step_ff, time_step_in;

   // item and product registers
   wcsa_pkg::req_type   item_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic                cell_ok_ff;
   wcsa_pkg::rsp_type   rsp_payload_ff, rsp_payload_in;
   logic [31:0]         wt_prod_ff, wt_prod_in;
   logic [63:0]         vx_prod_ff, vx_prod_in;
   logic [63:0]         vy_prod_ff, vy_prod_in;
   logic [63:0]         vz_prod_ff, vz_prod_in;
   logic [38:0]         ch_prod_ff, ch_prod_in;

   logic                req_accept;
   logic                cell_ok;
   logic [ADDR_W-1:0]   req_addr;
   logic                rsp_free;
   logic                rsp_load;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   wcsa_pkg::cell_type  ram_wr_data;
   logic [CELL_W-1:0]   ram_rd_data;
   wcsa_pkg::cell_type  ram_q;
   wcsa_pkg::cell_type  cell_new;

   assign req_stall  = (state_ff != wcsa_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign ram_q      = wcsa_pkg::cell_type'(ram_rd_data);

   // row-major cell address; modulo 2**ADDR_W throughout, exact when in range
   assign cell_ok = (32'(req_payload.time_index) < 32'(TIME_BINS)) &&
                    (32'(req_payload.x_index)    < 32'(X_BINS)) &&
                    (32'(req_payload.y_index)    < 32'(Y_BINS)) &&
                    (32'(req_payload.z_index)    < 32'(Z_BINS));

   assign req_addr = ((ADDR_W'(req_payload.time_index) * ADDR_W'(X_BINS)
                       + ADDR_W'(req_payload.x_index)) * ADDR_W'(Y_BINS)
                      + ADDR_W'(req_payload.y_index)) * ADDR_W'(Z_BINS)
                     + ADDR_W'(req_payload.z_index);

   wcsa_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wcsa_pkg::ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = wcsa_pkg::ST_IDLE;
            end
         end
         wcsa_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_payload.op == wcsa_pkg::OP_READ) begin
                  state_in = wcsa_pkg::ST_FETCH;
               end else if (!req_payload.dead && cell_ok) begin
                  state_in = wcsa_pkg::ST_FETCH;
               end
            end
         end
         wcsa_pkg::ST_FETCH: begin
            if (item_ff.op == wcsa_pkg::OP_ACCUM) begin
               state_in = wcsa_pkg::ST_WRITE;
            end else if (rsp_free) begin
               state_in = wcsa_pkg::ST_IDLE;
            end
         end
         wcsa_pkg::ST_WRITE: begin
            state_in = wcsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = wcsa_pkg::ST_CLEAR;
         end
      endcase
   end

   // merged cell after the saturating adds
   always_comb begin
      cell_new.count      = (ram_q.count == 32'hFFFF_FFFF) ? ram_q.count
                                                           : ram_q.count + 32'd1;
      cell_new.weight_sum = wcsa_pkg::sat_add_u(ram_q.weight_sum, {32'b0, wt_prod_ff});
      cell_new.vel_x_sum  = wcsa_pkg::sat_add_s(ram_q.vel_x_sum, vx_prod_ff);
      cell_new.vel_y_sum  = wcsa_pkg::sat_add_s(ram_q.vel_y_sum, vy_prod_ff);
      cell_new.vel_z_sum  = wcsa_pkg::sat_add_s(ram_q.vel_z_sum, vz_prod_ff);
      cell_new.charge_sum = wcsa_pkg::sat_add_u(ram_q.charge_sum, {25'b0, ch_prod_ff});
   end

   // outputs of the sequencer
   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = cell_new;
      rsp_load     = 1'b0;
      clr_addr_in  = clr_addr_ff;
      case (state_ff)
         wcsa_pkg::ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         wcsa_pkg::ST_FETCH: begin
            rsp_load = (item_ff.op == wcsa_pkg::OP_READ) && rsp_free;
         end
         wcsa_pkg::ST_WRITE: begin
            ram_wr_en = 1'b1;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // response register and products
   always_comb begin
      logic [63:0]        wt_full;
      logic signed [64:0] vx_full;
      logic signed [64:0] vy_full;
      logic signed [64:0] vz_full;
      wt_full = {32'b0, item_ff.weight} * {32'b0, time_step_ff};
      vx_full = $signed({1'b0, item_ff.weight}) * item_ff.vel_x;
      vy_full = $signed({1'b0, item_ff.weight}) * item_ff.vel_y;
      vz_full = $signed({1'b0, item_ff.weight}) * item_ff.vel_z;
      // drop the low 32 fraction bits of the Q16.48 weight term
      wt_prod_in = wt_full[63:32];
      vx_prod_in = vx_full[63:0];
      vy_prod_in = vy_full[63:0];
      vz_prod_in = vz_full[63:0];
      ch_prod_in = {7'b0, item_ff.weight} * {32'b0, item_ff.charge};

      rsp_payload_in = rsp_payload_ff;
      if (rsp_load) begin
         if (cell_ok_ff) begin
            rsp_payload_in.hit_count  = ram_q.count;
            rsp_payload_in.weight_sum = ram_q.weight_sum;
            rsp_payload_in.vel_x_sum  = ram_q.vel_x_sum;
            rsp_payload_in.vel_y_sum  = ram_q.vel_y_sum;
            rsp_payload_in.vel_z_sum  = ram_q.vel_z_sum;
            rsp_payload_in.charge_sum = ram_q.charge_sum;
         end else begin
            rsp_payload_in = '0;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      time_step_in = csr_wr_en ? csr_wr_data : time_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wcsa_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         time_step_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         time_step_ff <= time_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff    <= req_payload;
         addr_ff    <= req_addr;
         cell_ok_ff <= cell_ok;
      end
      rsp_payload_ff <= rsp_payload_in;
      wt_prod_ff     <= wt_prod_in;
      vx_prod_ff     <= vx_prod_in;
      vy_prod_ff     <= vy_prod_in;
      vz_prod_ff     <= vz_prod_in;
      ch_prod_ff     <= ch_prod_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_no_write_on_fetch : assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcsa_pkg::ST_FETCH) |-> !ram_wr_en)
      else $error("cell memory written while its read data is in use");

   a_read_goes_fetch : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_payload.op == wcsa_pkg::OP_READ)) |=>
         (state_ff == wcsa_pkg::ST_FETCH))
      else $error("read item did not move to fetch");

   a_rsp_from_read : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         $past(state_ff == wcsa_pkg::ST_FETCH && item_ff.op == wcsa_pkg::OP_READ))
      else $error("result raised without a read item in fetch");

   a_write_after_fetch : assert property (@(posedge clock) disable iff (reset)
      (state_ff == wcsa_pkg::ST_WRITE) |-> $past(state_ff == wcsa_pkg::ST_FETCH))
      else $error("write-back without a preceding fetch");

endmodule

// ----- hdl/wcsa_ram.sv -----
// ----------------------------------------------------------------------------
// wcsa_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// that holds until the next read.
// ----------------------------------------------------------------------------
module wcsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- verif/cell_sum_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// cell_sum_tracker_pkg
// Scoreboard for the weighted cell statistics accumulator: keeps its own copy
// of every touched cell and of the time step, and queues the sums that each
// accepted read item must return.
// ----------------------------------------------------------------------------
package cell_sum_tracker_pkg;

   import wcsa_pkg::*;

   localparam int TIME_BINS = 4;
   localparam int X_BINS    = 16;
   localparam int Y_BINS    = 16;
   localparam int Z_BINS    = 16;

   class cell_sum_tracker;

      logic [31:0] time_step;
      rsp_type     cells[int];
      rsp_type     pending_reads[$];
      int          mismatches;

      function new();
         time_step   = '0;
         mismatches  = 0;
      endfunction

      function void report(string what);
         mismatches++;
         $display("%0t ns  mismatch: %s", $time, what);
      endfunction

      static function logic [63:0] clamp_add_u(logic [63:0] a, logic [63:0] b);
         logic [64:0] s;
         s = 65'(a) + 65'(b);
         if (s[64]) begin
            return {64{1'b1}};
         end
         return s[63:0];
      endfunction

      // widen by one sign bit; disagreeing top bits mean the sum left the range
      static function logic [63:0] clamp_add_s(logic [63:0] a, logic [63:0] b);
         logic signed [64:0] s;
         s = $signed({a[63], a}) + $signed({b[63], b});
         if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         end
         return s[63:0];
      endfunction

      function void note_item(req_type it);
         int                 addr;
         bit                 in_grid;
         rsp_type            c;
         logic signed [63:0] wide_w;
         logic signed [63:0] vx;
         logic signed [63:0] vy;
         logic signed [63:0] vz;
         in_grid = int'(it.time_index) < TIME_BINS && int'(it.x_index) < X_BINS &&
                   int'(it.y_index) < Y_BINS && int'(it.z_index) < Z_BINS;
         addr = ((int'(it.time_index) * X_BINS + int'(it.x_index)) * Y_BINS
                 + int'(it.y_index)) * Z_BINS + int'(it.z_index);
         c = '0;
         if (in_grid && cells.exists(addr)) begin
            c = cells[addr];
         end
         if (it.op == OP_READ) begin
            pending_reads.insert(pending_reads.size(), c);
            return;
         end
         if (it.dead || !in_grid) begin
            return;
         end
         if (c.hit_count != {32{1'b1}}) begin
            c.hit_count = c.hit_count + 32'd1;
         end
         // Q16.16 times Q0.32 gives Q16.48: drop the low 32 bits
         c.weight_sum = clamp_add_u(c.weight_sum,
                                    (64'(it.weight) * 64'(time_step)) >> 32);
         wide_w = $signed({32'd0, it.weight});
         vx = {{32{it.vel_x[31]}}, it.vel_x};
         vy = {{32{it.vel_y[31]}}, it.vel_y};
         vz = {{32{it.vel_z[31]}}, it.vel_z};
         c.vel_x_sum  = clamp_add_s(c.vel_x_sum, wide_w * vx);
         c.vel_y_sum  = clamp_add_s(c.vel_y_sum, wide_w * vy);
         c.vel_z_sum  = clamp_add_s(c.vel_z_sum, wide_w * vz);
         c.charge_sum = clamp_add_u(c.charge_sum, 64'(it.weight) * 64'(it.charge));
         cells[addr] = c;
      endfunction

      function int pending();
         return pending_reads.size();
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_reads.size() == 0) begin
            report("result with no read waiting");
            return;
         end
         want = pending_reads.pop_front();
         if (got.hit_count !== want.hit_count) begin
            report($sformatf("hit_count %h, want %h", got.hit_count, want.hit_count));
         end
         if (got.weight_sum !== want.weight_sum) begin
            report($sformatf("weight_sum %h, want %h", got.weight_sum, want.weight_sum));
         end
         if (got.vel_x_sum !== want.vel_x_sum) begin
            report($sformatf("vel_x_sum %h, want %h", got.vel_x_sum, want.vel_x_sum));
         end
         if (got.vel_y_sum !== want.vel_y_sum) begin
            report($sformatf("vel_y_sum %h, want %h", got.vel_y_sum, want.vel_y_sum));
         end
         if (got.vel_z_sum !== want.vel_z_sum) begin
            report($sformatf("vel_z_sum %h, want %h", got.vel_z_sum, want.vel_z_sum));
         end
         if (got.charge_sum !== want.charge_sum) begin
            report($sformatf("charge_sum %h, want %h", got.charge_sum, want.charge_sum));
         end
      endfunction

   endclass

endpackage

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives accumulate and read items into the weighted cell statistics
// accumulator with random gaps and response stalls, mirrors every cell in a
// scoreboard and checks each read result field by field. Sweeps the time
// step through zero, one, mid and full scale, and forces velocity sums into
// saturation on a few heavily used cells.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import wcsa_pkg::*;
   import cell_sum_tracker_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   cell_sum_tracker ledger = new();

   bit          quiet;
   int          hold_off;
   logic [13:0] hot_cells[4];

   weighted_cell_stats_accumulator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_top failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            ledger.note_item(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            ledger.check_result(rsp_payload);
         end
      end
   end

   // result side: random hold before each item, or one long hold when asked
   initial begin
      int n;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off > 0) begin
            n        = hold_off;
            hold_off = 0;
         end else begin
            n = quiet ? 0 : $urandom_range(0, 7);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic req_type sample(logic op, logic dead, logic [1:0] t, logic [3:0] x,
                                      logic [3:0] y, logic [3:0] z, logic [31:0] w,
                                      logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                      logic [6:0] ch);
      req_type it;
      it.op         = op;
      it.dead       = dead;
      it.time_index = t;
      it.x_index    = x;
      it.y_index    = y;
      it.z_index    = z;
      it.weight     = w;
      it.vel_x      = vx;
      it.vel_y      = vy;
      it.vel_z      = vz;
      it.charge     = ch;
      return it;
   endfunction

   function automatic logic [31:0] pick_velocity();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 4095)) - 2048);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_sample();
      logic [13:0] a;
      logic [31:0] w;
      logic        op;
      a  = ($urandom_range(0, 3) != 0) ? hot_cells[$urandom_range(0, 3)]
                                       : 14'($urandom_range(0, 16383));
      op = ($urandom_range(0, 9) < 3) ? OP_READ : OP_ACCUM;
      case ($urandom_range(0, 9))
         0:       w = 32'd0;
         1, 2:    w = 32'hFFFF_FFFF;
         3, 4:    w = $urandom_range(0, 32'h3_FFFF);
         default: w = $urandom;
      endcase
      return sample(op, ($urandom_range(0, 7) == 0), a[13:12], a[11:8], a[7:4], a[3:0], w,
                    pick_velocity(), pick_velocity(), pick_velocity(),
                    7'($urandom_range(0, 127)));
   endfunction

   task automatic offer(input req_type item);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid, wait for every read to return, then let an accumulate finish
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.pending() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_time_step(input logic [31:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      ledger.time_step  = value;
   endtask

   task automatic run_phase(input int count, input logic [31:0] step, input bit calm,
                            input int hold);
      settle();
      write_time_step(step);
      quiet    = calm;
      hold_off = hold;
      repeat (count) offer(random_sample());
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      quiet        = 1'b0;
      hold_off     = 0;
      foreach (hot_cells[i]) hot_cells[i] = 14'($urandom_range(0, 16383));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_time_step(32'hFFFF_FFFF);
      // untouched corners read as zero
      offer(sample(OP_READ, 1'b0, 2'd0, 4'd0, 4'd0, 4'd0, '0, '0, '0, '0, '0));
      offer(sample(OP_READ, 1'b0, 2'd3, 4'hF, 4'hF, 4'hF, '0, '0, '0, '0, '0));
      // two full-scale samples drive the x velocity sum to its upper limit and the y velocity sum to its lower limit
      repeat (2) begin
         offer(sample(OP_ACCUM, 1'b0, 2'd3, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 7'h7F));
      end
      // dead bit on a read is ignored
      offer(sample(OP_READ, 1'b1, 2'd3, 4'hF, 4'hF, 4'hF, '0, '0, '0, '0, '0));
      // dead sample leaves the cell alone
      offer(sample(OP_ACCUM, 1'b1, 2'd0, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'h7F));
      offer(sample(OP_READ, 1'b0, 2'd0, 4'd0, 4'd0, 4'd0, '0, '0, '0, '0, '0));
      offer(sample(OP_ACCUM, 1'b0, 2'd0, 4'd0, 4'd0, 4'd0, 32'd0,
                   32'h1234_5678, 32'hDEAD_BEEF, 32'h8000_0000, 7'h00));
      offer(sample(OP_ACCUM, 1'b0, 2'd0, 4'd0, 4'd0, 4'd0, 32'd1,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 7'h01));
      offer(sample(OP_READ, 1'b0, 2'd0, 4'd0, 4'd0, 4'd0, '0, '0, '0, '0, '0));
      offer(sample(OP_ACCUM, 1'b0, 2'd2, 4'd9, 4'd6, 4'd5, 32'h0001_0000,
                   32'hFFFF_FF00, 32'h0000_0100, 32'hFFFF_FFFF, 7'h40));
      offer(sample(OP_READ, 1'b0, 2'd2, 4'd9, 4'd6, 4'd5, '0, '0, '0, '0, '0));
      // a zero time step still counts and sums velocity, but adds no weight
      settle();
      write_time_step(32'd0);
      offer(sample(OP_ACCUM, 1'b0, 2'd2, 4'd9, 4'd6, 4'd5, 32'hFFFF_FFFF,
                   32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 7'h7F));
      offer(sample(OP_READ, 1'b0, 2'd2, 4'd9, 4'd6, 4'd5, '0, '0, '0, '0, '0));

      run_phase(160, $urandom, 1'b0, 0);
      // full speed on both sides, with one long hold on results
      run_phase(160, 32'd1, 1'b1, 300);
      run_phase(160, 32'h8000_0000, 1'b0, 0);
      run_phase(160, 32'hFFFF_FFFF, 1'b0, 0);
      settle();

      if (ledger.mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
